// ===== sv/sync_framed_message_deframer_unit_macros.svh =====
// assertion shorthands for the deframer checker
`ifndef SYNC_FRAMED_MESSAGE_DEFRAMER_UNIT_MACROS_SVH
`define SYNC_FRAMED_MESSAGE_DEFRAMER_UNIT_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define SFD_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define SFD_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/sfd_pkg.sv =====
`default_nettype none

package sfd_pkg;

    localparam int BUFFER_BYTES       = 64;
    localparam int PTR_W              = $clog2(BUFFER_BYTES);
    localparam int CNT_W              = PTR_W + 1;
    localparam int DATA_PAYLOAD_BYTES = 8;
    localparam int HDR_BYTES          = 5;

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_FIRST  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_SECOND = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ID_CONFIG   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ID_DATA     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ID_READ_ACK = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ID_XRCE     = 3'd5;

    typedef enum logic [1:0] {
        KIND_CONFIG   = 2'd0,
        KIND_DATA     = 2'd1,
        KIND_READ_ACK = 2'd2,
        KIND_XRCE     = 2'd3
    } frame_kind_t;

endpackage

`default_nettype wire

// ===== sv/sfd_ram.sv =====
`default_nettype none

module sfd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== sv/sync_framed_message_deframer_unit.sv =====
// Sync-framed message deframer. Received bytes go into a 64-byte ring buffer
// (the oldest byte is dropped when it is full); a small sequencer then scans
// the buffer head for sync bytes, message id and frame size, drops one byte
// and rescans on a bad header, and reports each complete frame as one result
// per payload byte, or one result for a frame without payload. in_ready is
// high only while the sequencer is idle. The sequencer reads the buffer one
// header byte at a time through the single RAM read port, and reads each
// payload byte through the same port; an output stall holds it between
// payload bytes. The buffer needs no clearing after reset. The final result
// of a byte is held back one place so that it can carry the last flag;
// results leave through a one-entry output register.
`default_nettype none

module sync_framed_message_deframer_unit
    import sfd_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [7:0]           rx_byte,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic [1:0]                frame_kind,
    output logic [7:0]                command,
    output logic [15:0]               sequence_res,
    output logic [5:0]                payload_length,
    output logic                      payload_valid,
    output logic [7:0]                payload_byte,
    output logic [5:0]                byte_index,
    output logic                      frame_end,
    output logic                      last,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [7:0]           cfg_data
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_HDR,
        S_EVAL,
        S_PREQ,
        S_PCAP,
        S_FINISH
    } state_t;

    typedef struct packed {
        frame_kind_t kind;
        logic [7:0]  cmd;
        logic [15:0] seq;
        logic [5:0]  plen;
        logic        pvalid;
        logic [7:0]  pbyte;
        logic [5:0]  idx;
        logic        fend;
    } result_t;

    state_t            state_reg;
    logic [PTR_W-1:0]  head_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [2:0]        hk_reg;
    logic [7:0]        hdr_reg [HDR_BYTES];
    logic [5:0]        pi_reg;
    frame_kind_t       kind_reg;
    logic [7:0]        cmd_reg;
    logic [15:0]       seq_reg;
    logic [5:0]        plen_reg;
    logic [CNT_W-1:0]  size_reg;
    result_t           pend_reg;
    logic              pend_valid_reg;
    result_t           out_reg;
    logic              out_valid_reg;
    logic              out_last_reg;

    logic [7:0] sync_first_reg;
    logic [7:0] sync_second_reg;
    logic [7:0] id_config_reg;
    logic [7:0] id_data_reg;
    logic [7:0] id_read_ack_reg;
    logic [7:0] id_xrce_reg;

    logic              ram_wr_en;
    logic [PTR_W-1:0]  ram_wr_addr;
    logic              ram_rd_en;
    logic [PTR_W-1:0]  ram_rd_addr;
    logic [7:0]        ram_rd_data;

    logic              in_xfer;
    logic              out_free;
    logic              can_push;
    logic              out_load;
    logic [2:0]        hdr_count;
    logic              sync_ok;
    logic              id_known;
    frame_kind_t       ev_kind;
    logic [15:0]       ev_le16;
    logic [16:0]       ev_size;
    logic              ev_wait;
    logic              ev_bad;
    logic              ev_short;
    logic [5:0]        ev_plen;
    logic [7:0]        ev_cmd;
    logic [15:0]       ev_seq;
    result_t           ev_result;
    result_t           pay_result;

    sfd_ram #(
        .WIDTH (8),
        .DEPTH (BUFFER_BYTES)
    ) u_buf (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (rx_byte),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign in_ready    = (state_reg == S_IDLE);
    assign in_xfer     = in_valid && in_ready;
    assign out_free    = !out_valid_reg || out_ready;
    assign can_push    = !pend_valid_reg || out_free;
    assign ram_wr_en   = in_xfer;
    assign ram_wr_addr = head_reg + count_reg[PTR_W-1:0];
    assign hdr_count   = (count_reg >= CNT_W'(HDR_BYTES)) ? 3'(HDR_BYTES) : count_reg[2:0];

    // the held result moves into the output register this cycle
    assign out_load = pend_valid_reg && out_free
                      && (((state_reg == S_EVAL) && !ev_bad && !ev_short && (ev_plen == 6'd0))
                          || (state_reg == S_PCAP) || (state_reg == S_FINISH));

    always_comb
    begin
        ram_rd_en   = 1'b0;
        ram_rd_addr = head_reg + PTR_W'(hk_reg);
        if (state_reg == S_HDR)
        begin
            ram_rd_en = (hk_reg < hdr_count);
        end
        else if (state_reg == S_PREQ)
        begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = head_reg + PTR_W'(HDR_BYTES) + PTR_W'(pi_reg);
        end
    end

    // header classification
    always_comb
    begin
        sync_ok  = (hdr_reg[0] == sync_first_reg) && (hdr_reg[1] == sync_second_reg);
        id_known = 1'b1;
        ev_kind  = KIND_CONFIG;
        priority if (hdr_reg[2] == id_config_reg)
        begin
            ev_kind = KIND_CONFIG;
        end
        else if (hdr_reg[2] == id_data_reg)
        begin
            ev_kind = KIND_DATA;
        end
        else if (hdr_reg[2] == id_read_ack_reg)
        begin
            ev_kind = KIND_READ_ACK;
        end
        else if (hdr_reg[2] == id_xrce_reg)
        begin
            ev_kind = KIND_XRCE;
        end
        else
        begin
            id_known = 1'b0;
        end

        ev_le16 = {hdr_reg[4], hdr_reg[3]};
        unique case (ev_kind)
            KIND_CONFIG:   ev_size = 17'd4;
            KIND_DATA:     ev_size = 17'(HDR_BYTES + DATA_PAYLOAD_BYTES);
            KIND_READ_ACK: ev_size = 17'(HDR_BYTES);
            KIND_XRCE:     ev_size = 17'(HDR_BYTES) + {1'b0, ev_le16};
            default:       ev_size = 17'd4;
        endcase

        ev_wait  = (ev_kind == KIND_XRCE) && (count_reg < CNT_W'(HDR_BYTES));
        ev_bad   = !sync_ok || !id_known
                   || (!ev_wait && (ev_size > 17'(BUFFER_BYTES)));
        ev_short = ev_wait || ({10'd0, count_reg} < ev_size);
        ev_plen  = ((ev_kind == KIND_DATA) || (ev_kind == KIND_XRCE))
                   ? 6'(ev_size - 17'(HDR_BYTES)) : 6'd0;
        ev_cmd   = (ev_kind == KIND_CONFIG) ? hdr_reg[3] : 8'd0;
        ev_seq   = ((ev_kind == KIND_DATA) || (ev_kind == KIND_READ_ACK)) ? ev_le16 : 16'd0;

        ev_result.kind   = ev_kind;
        ev_result.cmd    = ev_cmd;
        ev_result.seq    = ev_seq;
        ev_result.plen   = 6'd0;
        ev_result.pvalid = 1'b0;
        ev_result.pbyte  = 8'd0;
        ev_result.idx    = 6'd0;
        ev_result.fend   = 1'b1;

        pay_result.kind   = kind_reg;
        pay_result.cmd    = cmd_reg;
        pay_result.seq    = seq_reg;
        pay_result.plen   = plen_reg;
        pay_result.pvalid = 1'b1;
        pay_result.pbyte  = ram_rd_data;
        pay_result.idx    = pi_reg;
        pay_result.fend   = (pi_reg + 6'd1 == plen_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_first_reg  <= '0;
            sync_second_reg <= '0;
            id_config_reg   <= '0;
            id_data_reg     <= '0;
            id_read_ack_reg <= '0;
            id_xrce_reg     <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_SYNC_FIRST:  sync_first_reg  <= cfg_data;
                CFG_SYNC_SECOND: sync_second_reg <= cfg_data;
                CFG_ID_CONFIG:   id_config_reg   <= cfg_data;
                CFG_ID_DATA:     id_data_reg     <= cfg_data;
                CFG_ID_READ_ACK: id_read_ack_reg <= cfg_data;
                CFG_ID_XRCE:     id_xrce_reg     <= cfg_data;
                default:         ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            head_reg       <= '0;
            count_reg      <= '0;
            hk_reg         <= '0;
            pi_reg         <= '0;
            kind_reg       <= KIND_CONFIG;
            cmd_reg        <= '0;
            seq_reg        <= '0;
            plen_reg       <= '0;
            size_reg       <= '0;
            pend_reg       <= '0;
            pend_valid_reg <= 1'b0;
            out_reg        <= '0;
            out_valid_reg  <= 1'b0;
            out_last_reg   <= 1'b0;
            for (int i = 0; i < HDR_BYTES; i++)
            begin
                hdr_reg[i] <= '0;
            end
        end
        else
        begin
            if (out_valid_reg && out_ready && !out_load)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_xfer)
                    begin
                        if (count_reg == CNT_W'(BUFFER_BYTES))
                        begin
                            head_reg <= head_reg + PTR_W'(1);
                        end
                        else
                        begin
                            count_reg <= count_reg + CNT_W'(1);
                        end
                        state_reg <= S_SCAN;
                    end
                end

                S_SCAN:
                begin
                    hk_reg <= '0;
                    if (count_reg < CNT_W'(3))
                    begin
                        state_reg <= S_FINISH;
                    end
                    else
                    begin
                        state_reg <= S_HDR;
                    end
                end

                S_HDR:
                begin
                    if (hk_reg != 3'd0)
                    begin
                        hdr_reg[hk_reg - 3'd1] <= ram_rd_data;
                    end
                    if (hk_reg == hdr_count)
                    begin
                        state_reg <= S_EVAL;
                    end
                    else
                    begin
                        hk_reg <= hk_reg + 3'd1;
                    end
                end

                S_EVAL:
                begin
                    if (ev_bad)
                    begin
                        head_reg  <= head_reg + PTR_W'(1);
                        count_reg <= count_reg - CNT_W'(1);
                        state_reg <= S_SCAN;
                    end
                    else if (ev_short)
                    begin
                        state_reg <= S_FINISH;
                    end
                    else if (ev_plen == 6'd0)
                    begin
                        // frame without payload: a single result
                        if (can_push)
                        begin
                            if (pend_valid_reg)
                            begin
                                out_reg       <= pend_reg;
                                out_last_reg  <= 1'b0;
                                out_valid_reg <= 1'b1;
                            end
                            pend_reg       <= ev_result;
                            pend_valid_reg <= 1'b1;
                            head_reg       <= head_reg + ev_size[PTR_W-1:0];
                            count_reg      <= count_reg - ev_size[CNT_W-1:0];
                            state_reg      <= S_SCAN;
                        end
                    end
                    else
                    begin
                        kind_reg  <= ev_kind;
                        cmd_reg   <= ev_cmd;
                        seq_reg   <= ev_seq;
                        plen_reg  <= ev_plen;
                        size_reg  <= ev_size[CNT_W-1:0];
                        pi_reg    <= '0;
                        state_reg <= S_PREQ;
                    end
                end

                S_PREQ:
                begin
                    state_reg <= S_PCAP;
                end

                S_PCAP:
                begin
                    if (can_push)
                    begin
                        if (pend_valid_reg)
                        begin
                            out_reg       <= pend_reg;
                            out_last_reg  <= 1'b0;
                            out_valid_reg <= 1'b1;
                        end
                        pend_reg       <= pay_result;
                        pend_valid_reg <= 1'b1;
                        if (pay_result.fend)
                        begin
                            head_reg  <= head_reg + size_reg[PTR_W-1:0];
                            count_reg <= count_reg - size_reg;
                            state_reg <= S_SCAN;
                        end
                        else
                        begin
                            pi_reg    <= pi_reg + 6'd1;
                            state_reg <= S_PREQ;
                        end
                    end
                end

                S_FINISH:
                begin
                    if (!pend_valid_reg)
                    begin
                        state_reg <= S_IDLE;
                    end
                    else if (out_free)
                    begin
                        out_reg        <= pend_reg;
                        out_last_reg   <= 1'b1;
                        out_valid_reg  <= 1'b1;
                        pend_valid_reg <= 1'b0;
                        state_reg      <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid      = out_valid_reg;
    assign frame_kind     = out_reg.kind;
    assign command        = out_reg.cmd;
    assign sequence_res   = out_reg.seq;
    assign payload_length = out_reg.plen;
    assign payload_valid  = out_reg.pvalid;
    assign payload_byte   = out_reg.pbyte;
    assign byte_index     = out_reg.idx;
    assign frame_end      = out_reg.fend;
    assign last           = out_last_reg;

endmodule

`default_nettype wire

// ===== sv/sfd_checker.sv =====
`default_nettype none

`include "sync_framed_message_deframer_unit_macros.svh"

module sfd_checker
    import sfd_pkg::*;
(
    input wire logic                 clk,
    input wire logic                 rst_n,
    input wire logic                 out_valid,
    input wire logic                 out_ready,
    input wire logic [1:0]           frame_kind,
    input wire logic [7:0]           command,
    input wire logic [15:0]          sequence_res,
    input wire logic [5:0]           payload_length,
    input wire logic                 payload_valid,
    input wire logic [7:0]           payload_byte,
    input wire logic [5:0]           byte_index,
    input wire logic                 frame_end,
    input wire logic                 last
);

    // a stalled result transfer holds
    `SFD_ASSERT_NXT(a_out_hold, out_valid && !out_ready,
        out_valid && $stable(payload_byte) && $stable(frame_end) && $stable(last),
        "result changed while stalled")

    // a frame without payload is one closing result with zero payload fields
    `SFD_ASSERT_IMP(a_no_payload, out_valid && !payload_valid,
        payload_length == 6'd0 && payload_byte == 8'd0 && byte_index == 6'd0 && frame_end,
        "bad empty-payload result")

    // payload index stays in range and frame end marks the final byte
    `SFD_ASSERT_IMP(a_payload_idx, out_valid && payload_valid,
        (byte_index < payload_length) && (frame_end == (byte_index + 6'd1 == payload_length)),
        "bad payload index")

    // only config frames carry a command
    `SFD_ASSERT_IMP(a_cmd_zero, out_valid && frame_kind != KIND_CONFIG, command == 8'd0,
        "command on non-config frame")

    // config and xrce frames carry no sequence
    `SFD_ASSERT_IMP(a_seq_zero,
        out_valid && (frame_kind == KIND_CONFIG || frame_kind == KIND_XRCE),
        sequence_res == 16'd0, "sequence on config or xrce frame")

endmodule

bind sync_framed_message_deframer_unit sfd_checker u_sfd_checker (.*);

`default_nettype wire

// ===== dv/sync_framed_message_deframer_unit_checker.sv =====
`timescale 1ns / 1ps

module sync_framed_message_deframer_unit_checker
    import sfd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_ready,
    input  logic [7:0]           rx_byte,
    input  logic                 out_valid,
    input  logic                 out_ready,
    input  logic [1:0]           frame_kind,
    input  logic [7:0]           command,
    input  logic [15:0]          sequence_res,
    input  logic [5:0]           payload_length,
    input  logic                 payload_valid,
    input  logic [7:0]           payload_byte,
    input  logic [5:0]           byte_index,
    input  logic                 frame_end,
    input  logic                 last,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]           cfg_data,
    output int                   fail_count,
    output int                   waiting,
    output int                   results_seen,
    output int                   frames_seen
);

    localparam int RESULTS_PER_BYTE = 64;

    typedef struct {
        frame_kind_t kind;
        logic [7:0]  cmd;
        logic [15:0] seq;
        logic [5:0]  plen;
        logic        pvalid;
        logic [7:0]  pbyte;
        logic [5:0]  idx;
        logic        fend;
        logic        lst;
    } frame_result_t;

    logic [7:0] sync_a, sync_b;
    logic [7:0] id_cfg, id_dat, id_ack, id_xrc;
    logic [7:0] rx_window[$];
    frame_result_t due_results[$];
    int mismatches;
    int n_results;
    int n_frames;

    task automatic compare_field(input string name, input int unsigned want,
                                 input int unsigned got);
        if (want != got)
        begin
            $error("%s expected %0d got %0d", name, want, got);
            mismatches++;
        end
    endtask

    // runs the scan over the byte window after one new byte arrives
    task automatic deframe_byte(input logic [7:0] b);
        int unsigned size;
        int unsigned plen;
        int n_new;
        bit known;
        bit have_prev;
        frame_kind_t kind;
        logic [7:0] cmd;
        logic [15:0] seq;
        frame_result_t r;
        frame_result_t prev;
        n_new = 0;
        have_prev = 0;
        kind = KIND_CONFIG;
        if (rx_window.size() >= BUFFER_BYTES)
            void'(rx_window.pop_front());
        rx_window.push_back(b);
        while (rx_window.size() >= 3)
        begin
            if (rx_window[0] != sync_a || rx_window[1] != sync_b)
            begin
                void'(rx_window.pop_front());
                continue;
            end
            known = 1;
            if (rx_window[2] == id_cfg)
                kind = KIND_CONFIG;
            else if (rx_window[2] == id_dat)
                kind = KIND_DATA;
            else if (rx_window[2] == id_ack)
                kind = KIND_READ_ACK;
            else if (rx_window[2] == id_xrc)
                kind = KIND_XRCE;
            else
                known = 0;
            if (!known)
            begin
                void'(rx_window.pop_front());
                continue;
            end
            case (kind)
                KIND_CONFIG:   size = 4;
                KIND_DATA:     size = HDR_BYTES + DATA_PAYLOAD_BYTES;
                KIND_READ_ACK: size = HDR_BYTES;
                default:
                    size = (rx_window.size() < HDR_BYTES) ? 0 :
                           HDR_BYTES + int'({rx_window[4], rx_window[3]});
            endcase
            if (size > BUFFER_BYTES)
            begin
                void'(rx_window.pop_front());
                continue;
            end
            if (size == 0 || rx_window.size() < size)
                break;
            cmd = (kind == KIND_CONFIG) ? rx_window[3] : 8'd0;
            seq = (kind == KIND_DATA || kind == KIND_READ_ACK) ?
                  {rx_window[4], rx_window[3]} : 16'd0;
            plen = (kind == KIND_DATA || kind == KIND_XRCE) ? size - HDR_BYTES : 0;
            for (int i = 0; i < ((plen == 0) ? 1 : plen); i++)
            begin
                if (n_new >= RESULTS_PER_BYTE)
                    break;
                r.kind = kind;
                r.cmd = cmd;
                r.seq = seq;
                r.plen = plen[5:0];
                r.pvalid = (plen != 0);
                r.pbyte = (plen != 0) ? rx_window[HDR_BYTES + i] : 8'd0;
                r.idx = (plen != 0) ? i[5:0] : 6'd0;
                r.fend = (plen == 0) || (i + 1 == plen);
                r.lst = 0;
                if (have_prev)
                    due_results.push_back(prev);
                prev = r;
                have_prev = 1;
                n_new++;
            end
            repeat (size) void'(rx_window.pop_front());
        end
        if (have_prev)
        begin
            prev.lst = 1;
            due_results.push_back(prev);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        frame_result_t want;
        if (!rst_n)
        begin
            sync_a = 8'd0;
            sync_b = 8'd0;
            id_cfg = 8'd0;
            id_dat = 8'd0;
            id_ack = 8'd0;
            id_xrc = 8'd0;
            rx_window.delete();
            due_results.delete();
            mismatches = 0;
            n_results = 0;
            n_frames = 0;
            fail_count <= 0;
            waiting <= 0;
            results_seen <= 0;
            frames_seen <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_SYNC_FIRST:  sync_a = cfg_data;
                    CFG_SYNC_SECOND: sync_b = cfg_data;
                    CFG_ID_CONFIG:   id_cfg = cfg_data;
                    CFG_ID_DATA:     id_dat = cfg_data;
                    CFG_ID_READ_ACK: id_ack = cfg_data;
                    CFG_ID_XRCE:     id_xrc = cfg_data;
                    default: ;
                endcase
            end
            if (out_valid && out_ready)
            begin
                n_results++;
                if (frame_end)
                    n_frames++;
                if (due_results.size() == 0)
                begin
                    $error("result transfer with nothing expected");
                    mismatches++;
                end
                else
                begin
                    want = due_results.pop_front();
                    compare_field("frame_kind", want.kind, frame_kind);
                    compare_field("command", want.cmd, command);
                    compare_field("sequence_res", want.seq, sequence_res);
                    compare_field("payload_length", want.plen, payload_length);
                    compare_field("payload_valid", want.pvalid, payload_valid);
                    compare_field("payload_byte", want.pbyte, payload_byte);
                    compare_field("byte_index", want.idx, byte_index);
                    compare_field("frame_end", want.fend, frame_end);
                    compare_field("last", want.lst, last);
                end
            end
            if (in_valid && in_ready)
                deframe_byte(rx_byte);
            fail_count <= mismatches;
            waiting <= due_results.size();
            results_seen <= n_results;
            frames_seen <= n_frames;
        end
    end

endmodule

// ===== dv/sync_framed_message_deframer_unit_tb.sv =====
`timescale 1ns / 1ps

module sync_framed_message_deframer_unit_tb;
    import sfd_pkg::*;

    localparam int DRAIN_CYCLES = 1000;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    logic [7:0]           rx_byte;
    logic                 out_valid;
    logic                 out_ready;
    logic [1:0]           frame_kind;
    logic [7:0]           command;
    logic [15:0]          sequence_res;
    logic [5:0]           payload_length;
    logic                 payload_valid;
    logic [7:0]           payload_byte;
    logic [5:0]           byte_index;
    logic                 frame_end;
    logic                 last;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [7:0]           cfg_data;

    int fail_count;
    int waiting;
    int results_seen;
    int frames_seen;

    logic [7:0] cur_sync_a, cur_sync_b;
    logic [7:0] cur_id[4];
    bit steady;
    int bytes_sent;
    int settings_used;

    sync_framed_message_deframer_unit dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .rx_byte        (rx_byte),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .frame_kind     (frame_kind),
        .command        (command),
        .sequence_res   (sequence_res),
        .payload_length (payload_length),
        .payload_valid  (payload_valid),
        .payload_byte   (payload_byte),
        .byte_index     (byte_index),
        .frame_end      (frame_end),
        .last           (last),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    sync_framed_message_deframer_unit_checker frame_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .rx_byte        (rx_byte),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .frame_kind     (frame_kind),
        .command        (command),
        .sequence_res   (sequence_res),
        .payload_length (payload_length),
        .payload_valid  (payload_valid),
        .payload_byte   (payload_byte),
        .byte_index     (byte_index),
        .frame_end      (frame_end),
        .last           (last),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .fail_count     (fail_count),
        .waiting        (waiting),
        .results_seen   (results_seen),
        .frames_seen    (frames_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #2000000;
        $display("TB_ERROR");
        $finish;
    end

    // result side: random stall before each transfer
    initial
    begin
        int stall;
        out_ready <= 1'b0;
        @(posedge clk);
        forever
        begin
            stall = steady ? 0 : $urandom_range(0, 3);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
        end
    end

    task automatic offer_byte(input logic [7:0] b);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 3);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte <= b;
        do @(posedge clk); while (!in_ready);
        bytes_sent++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
    endtask

    task automatic load_setting(input logic [7:0] sa, input logic [7:0] sb,
                                input logic [7:0] ic, input logic [7:0] id,
                                input logic [7:0] ia, input logic [7:0] ix);
        write_reg(CFG_SYNC_FIRST, sa);
        write_reg(CFG_SYNC_SECOND, sb);
        write_reg(CFG_ID_CONFIG, ic);
        write_reg(CFG_ID_DATA, id);
        write_reg(CFG_ID_READ_ACK, ia);
        write_reg(CFG_ID_XRCE, ix);
        cfg_we <= 1'b0;
        cur_sync_a = sa;
        cur_sync_b = sb;
        cur_id[KIND_CONFIG] = ic;
        cur_id[KIND_DATA] = id;
        cur_id[KIND_READ_ACK] = ia;
        cur_id[KIND_XRCE] = ix;
        settings_used++;
    endtask

    // wait for every expected result, then let the sequencer finish any rescan
    task automatic settle();
        in_valid <= 1'b0;
        do @(posedge clk); while (waiting != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // one frame of the given kind; xlen below zero picks a random xrce length
    task automatic send_frame(input int kind, input int xlen, input bit broken);
        logic [7:0] fq[$];
        int len;
        int keep;
        int pos;
        fq = {};
        fq.push_back(cur_sync_a);
        fq.push_back(cur_sync_b);
        fq.push_back(cur_id[kind]);
        case (kind)
            KIND_CONFIG:
                fq.push_back(8'($urandom_range(0, 255)));
            KIND_DATA:
                repeat (2 + DATA_PAYLOAD_BYTES) fq.push_back(8'($urandom_range(0, 255)));
            KIND_READ_ACK:
                repeat (2) fq.push_back(8'($urandom_range(0, 255)));
            default:
            begin
                len = xlen;
                if (len < 0)
                begin
                    case ($urandom_range(0, 9))
                        0:       len = $urandom_range(60, 65535);
                        1, 2:    len = $urandom_range(7, 59);
                        default: len = $urandom_range(0, 6);
                    endcase
                end
                fq.push_back(len[7:0]);
                fq.push_back(len[15:8]);
                if (len <= BUFFER_BYTES - HDR_BYTES)
                    repeat (len) fq.push_back(8'($urandom_range(0, 255)));
            end
        endcase
        if (broken)
        begin
            if ($urandom_range(0, 1) == 0)
            begin
                keep = $urandom_range(1, fq.size() - 1);
                while (fq.size() > keep) void'(fq.pop_back());
            end
            else
            begin
                pos = $urandom_range(0, fq.size() - 1);
                fq[pos] = fq[pos] ^ 8'($urandom_range(1, 255));
            end
        end
        foreach (fq[i]) offer_byte(fq[i]);
    endtask

    task automatic random_traffic(input int count);
        int target;
        int pick;
        target = bytes_sent + count;
        while (bytes_sent < target)
        begin
            if ($urandom_range(0, 7) == 0)
                steady = ~steady;
            pick = $urandom_range(0, 99);
            if (pick < 10)
                repeat ($urandom_range(1, 4)) offer_byte(8'($urandom_range(0, 255)));
            else
                send_frame($urandom_range(0, 3), -1, pick < 22);
        end
    endtask

    initial
    begin
        logic [7:0] directed[$];
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        rx_byte <= 8'd0;
        cfg_we <= 1'b0;
        cfg_index <= CFG_SYNC_FIRST;
        cfg_data <= 8'd0;
        cur_sync_a = 8'd0;
        cur_sync_b = 8'd0;
        foreach (cur_id[i]) cur_id[i] = 8'd0;
        steady = 0;
        bytes_sent = 0;
        settings_used = 1;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset values: zero sync and every id equal, config wins
        random_traffic(15);
        settle();

        load_setting(8'hAA, 8'h55, 8'h01, 8'h02, 8'h03, 8'h04);
        // config, read ack, short xrce, bad sync with unknown id, oversize xrce
        directed = {8'hAA, 8'h55, 8'h01, 8'hFF,
                    8'hAA, 8'h55, 8'h03, 8'h00, 8'h00,
                    8'hAA, 8'h55, 8'h04, 8'h01, 8'h00, 8'hFF,
                    8'h00, 8'hAA, 8'h55, 8'h77,
                    8'hAA, 8'h55, 8'h04, 8'hFF, 8'hFF};
        foreach (directed[i]) offer_byte(directed[i]);
        random_traffic(40);
        settle();

        load_setting(8'hFF, 8'h00, 8'h00, 8'hFF, 8'h7F, 8'h80);
        random_traffic(25);
        settle();

        // shared ids: config, data and xrce alike
        load_setting(8'h3C, 8'hC3, 8'h10, 8'h10, 8'h20, 8'h10);
        random_traffic(20);
        settle();

        // shared ids: data shadows xrce
        load_setting(8'h5A, 8'h5A, 8'h11, 8'h22, 8'h33, 8'h22);
        random_traffic(20);
        settle();

        load_setting(8'hAA, 8'h55, 8'h01, 8'h02, 8'h03, 8'h04);
        steady = 1;
        send_frame(KIND_XRCE, BUFFER_BYTES - HDR_BYTES, 0);
        send_frame(KIND_XRCE, BUFFER_BYTES - HDR_BYTES + 1, 0);
        send_frame(KIND_DATA, -1, 0);
        random_traffic(15);
        steady = 0;
        settle();

        $display("%0d bytes sent under %0d register settings", bytes_sent, settings_used);
        $display("%0d results checked, %0d complete frames", results_seen, frames_seen);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
